FILE: rtl/crcws_pkg.sv
// ----------------------------------------------------------------------------
// CRC-32C word-sum hash package
// Shared types, constants and the unrolled CRC-32C word step.
// ----------------------------------------------------------------------------
package crcws_pkg;

  typedef logic [31:0] word_t;
  typedef logic [2:0]  count_t;
  typedef logic [31:0][31:0] crc_cols_t;

  // Reset value of the seed register.
  localparam word_t SEED_RESET = 32'h1234_5678;

  // Bit-reversed Castagnoli polynomial 0x1EDC6F41.
  localparam word_t POLY_REFLECTED = 32'h82F6_3B78;

  // Byte count of a whole chunk; larger counts saturate to it.
  localparam count_t FULL_COUNT = 3'd4;

  // Number of bytes that a short tail can carry.
  localparam int unsigned TAIL_BYTES = 3;

  // Item passed from the CRC stage to the accumulator.
  typedef struct packed {
    logic  valid;
    logic  last;
    word_t addend;
  } crcws_item_t;

  // Thirty-two reflected shifts of the CRC register; used only to build
  // the constant column table below.
  function automatic word_t crc_shift32(input word_t start);
    word_t c;
    c = start;
    for (int i = 0; i < 32; i++) begin
      c = (c >> 1) ^ (c[0] ? POLY_REFLECTED : '0);
    end
    return c;
  endfunction

  // Response of the word step to each single input bit.
  function automatic crc_cols_t crc_col_table();
    crc_cols_t cols;
    for (int i = 0; i < 32; i++) begin
      cols[i] = crc_shift32(word_t'(1) << i);
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_col_table();

  // The word step is linear over GF(2): an XOR of the columns of set bits.
  function automatic word_t crc_lin(input word_t d);
    word_t r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      r = r ^ (d[i] ? CRC_COLS[i] : '0);
    end
    return r;
  endfunction

  // Step response of the reset seed alone.
  localparam word_t SEED_CRC_RESET = crc_lin(SEED_RESET);

  // Tail packing: each sign-extended byte j weighted by 16^j, modulo 2^32.
  function automatic word_t pack_tail(input word_t w, input count_t cnt);
    word_t packed_val;
    word_t b;
    packed_val = '0;
    for (int j = 0; j < TAIL_BYTES; j++) begin
      b = {{24{w[8*j+7]}}, w[8*j +: 8]};
      if (count_t'(j) < cnt) begin
        packed_val = packed_val + (b << (4 * j));
      end
    end
    return packed_val;
  endfunction

endpackage

FILE: rtl/crcws_stage.sv
// ----------------------------------------------------------------------------
// CRC-32C word-sum hash: input and CRC stage
// Registers each incoming item, packs the tail, runs the word step and
// registers the value to be added to the running sum.
// ----------------------------------------------------------------------------
module crcws_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  crcws_pkg::word_t      chunk_word,
  input  crcws_pkg::count_t     valid_bytes,
  input  logic                  last,
  input  crcws_pkg::word_t      seed_crc,
  output crcws_pkg::crcws_item_t stage_out,
  input  logic                  stage_ready
);
  import crcws_pkg::*;

  logic   a_valid;
  word_t  a_word;
  count_t a_count;
  logic   a_last;

  logic   b_ready;
  logic   a_take;
  logic   in_take;
  logic   full_word;
  word_t  operand;
  word_t  crc_val;
  word_t  addend_next;

  // Handshake: the input register frees up when its item moves on.
  assign b_ready  = !stage_out.valid || stage_ready;
  assign a_take   = a_valid && b_ready;
  assign in_stall = a_valid && !b_ready;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (a_take) begin
      a_valid <= 1'b0;
    end
    if (in_take) begin
      a_word  <= chunk_word;
      a_count <= valid_bytes;
      a_last  <= last;
    end
  end

  // Operand selection and word step. The seed term enters by linearity;
  // a full final chunk also adds the hash of the empty tail.
  always_comb begin
    full_word   = !a_last || (a_count >= FULL_COUNT);
    operand     = full_word ? a_word : pack_tail(a_word, a_count);
    crc_val     = crc_lin(operand) ^ seed_crc;
    addend_next = crc_val + ((a_last && full_word) ? seed_crc : '0);
  end

  // Addend register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (b_ready) begin
      stage_out.valid <= a_valid;
    end
    if (a_take) begin
      stage_out.last   <= a_last;
      stage_out.addend <= addend_next;
    end
  end

endmodule

FILE: rtl/crcws_accum.sv
// ----------------------------------------------------------------------------
// CRC-32C word-sum hash: accumulator and result register
// Adds each addend into the running sum and presents the hash on the
// final item of a string.
// ----------------------------------------------------------------------------
module crcws_accum (
  input  logic                   clk,
  input  logic                   rst,
  input  crcws_pkg::crcws_item_t stage_in,
  output logic                   stage_ready,
  output logic                   out_valid,
  input  logic                   out_stall,
  output crcws_pkg::word_t       hash_value
);
  import crcws_pkg::*;

  word_t running_sum;
  word_t total;
  logic  out_free;
  logic  consume;

  // Only a final item needs room in the result register.
  assign out_free    = !out_valid || !out_stall;
  assign stage_ready = !stage_in.last || out_free;
  assign consume     = stage_in.valid && stage_ready;
  assign total       = running_sum + stage_in.addend;

  // Running sum, cleared once a string is finished.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (consume) begin
      running_sum <= stage_in.last ? '0 : total;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && stage_in.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (consume && stage_in.last) begin
      hash_value <= total;
    end
  end

endmodule

FILE: rtl/crc32c_word_sum_hash_top.sv
// ----------------------------------------------------------------------------
// CRC-32C word-sum hash top level
// Additive hash of a byte string delivered as 32-bit little-endian chunks.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one chunk per item:
// chunk_word with the first byte in bits 7:0, valid_bytes and last.
// valid_bytes counts only on the final item; other chunks are whole words.
// Each chunk is run through a CRC-32C word step from the seed and summed.
// The output channel (out_valid / out_stall) gives one hash_value item per
// string, on its final chunk; the sum then restarts from zero.
// An item is taken every cycle while in_stall is low. The result of a final
// chunk passes through the input register, then the addend register, then
// the result register. A stalled result stays in the result register while
// non-final chunks keep flowing; only a second final chunk waits behind it,
// and the input stalls once both internal registers are occupied. The seed
// is written through cfg_we / cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. Its CRC term
// is registered from the seed register, so a write takes effect through the
// seed register and then the seed term register. Synchronous reset empties
// the pipeline, clears the running sum and restores the seed to 0x12345678.
// ----------------------------------------------------------------------------
module crc32c_word_sum_hash_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  crcws_pkg::word_t    cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  crcws_pkg::word_t    chunk_word,
  input  crcws_pkg::count_t   valid_bytes,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_stall,
  output crcws_pkg::word_t    hash_value
);
  import crcws_pkg::*;

  word_t       seed;
  word_t       seed_crc;
  crcws_item_t stage_item;
  logic        stage_ready;

  // Seed register and its registered word-step term.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed     <= SEED_RESET;
      seed_crc <= SEED_CRC_RESET;
    end else begin
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
      seed_crc <= crc_lin(seed);
    end
  end

  // Input register and CRC stage.
  crcws_stage u_stage (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .chunk_word  (chunk_word),
    .valid_bytes (valid_bytes),
    .last        (last),
    .seed_crc    (seed_crc),
    .stage_out   (stage_item),
    .stage_ready (stage_ready)
  );

  // Accumulator and result register.
  crcws_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .stage_in    (stage_item),
    .stage_ready (stage_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hash_value  (hash_value)
  );

`ifndef SYNTHESIS
  // The addend stage holds back only a final item behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    stage_item.valid && !stage_ready |-> stage_item.last && out_valid && out_stall)
    else $error("addend stage blocked without a waiting result");

  // A fresh result always comes from a final item in the addend stage.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(stage_item.valid && stage_item.last))
    else $error("result appeared without a final item");

  // The seed term is the registered word step of the seed register.
  assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> ##1 seed_crc == crc_lin(seed))
    else $error("seed term not refreshed after a write");
`endif

endmodule
